FILE: sv/rhfe_pkg.sv
`timescale 1ns / 1ps
// Shared types, key constant and character helpers for the relay hex field extractor.
package rhfe_pkg;

   localparam int unsigned KEY_LEN = 9;
   localparam int unsigned PROG_W = 4;

   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_ARM = 1'b1;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_OPEN = 8'h7B;
   localparam logic [7:0] CH_CLOSE = 8'h7D;

   // The key "relay":" spelled out one character per entry.
   localparam logic [7:0] RELAY_KEY [KEY_LEN] = '{
      8'h22, 8'h72, 8'h65, 8'h6C, 8'h61, 8'h79, 8'h22, 8'h3A, 8'h22
   };

   // One classified transaction as it travels from the front to the back.
   typedef struct packed {
      logic               arm;
      logic               is_open;
      logic               is_close;
      logic               is_quote;
      logic [3:0]         nibble;
      logic [KEY_LEN-1:0] key_hit;
   } rhfe_class_type;

   // Hex value of a character; anything that is not a hex digit gives zero.
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         n = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n = 4'(c - 8'h37);
      end
      return n;
   endfunction

endpackage

FILE: sv/rhfe_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response streams.
interface rhfe_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] ch;

   modport source (output valid, output mode, output ch, input ready);
   modport sink (input valid, input mode, input ch, output ready);
endinterface

interface rhfe_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] data_byte;
   logic       awaiting;

   modport source (output valid, output byte_valid, output data_byte, output awaiting,
                   input ready);
   modport sink (input valid, input byte_valid, input data_byte, input awaiting,
                 output ready);
endinterface

FILE: sv/rhfe_front.sv
`timescale 1ns / 1ps
// Front end: accepts request transactions and classifies each character.
module rhfe_front
   import rhfe_pkg::*;
(
   rhfe_req_if.sink        req_chan,
   input  logic            queue_full,
   output logic            push,
   output rhfe_class_type  push_item
);

   logic is_char;

   assign req_chan.ready = !queue_full;
   assign push = req_chan.valid && !queue_full;
   assign is_char = (req_chan.mode == MODE_CHAR);

   always_comb begin
      push_item.arm = (req_chan.mode == MODE_ARM);
      push_item.is_open = is_char && (req_chan.ch == CH_OPEN);
      push_item.is_close = is_char && (req_chan.ch == CH_CLOSE);
      push_item.is_quote = (req_chan.ch == CH_QUOTE);
      push_item.nibble = nibble_of(req_chan.ch);
      for (int i = 0; i < KEY_LEN; i++) begin
         push_item.key_hit[i] = (req_chan.ch == RELAY_KEY[i]);
      end
   end

endmodule

FILE: sv/rhfe_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified transactions between the front and the back.
module rhfe_queue
   import rhfe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rhfe_class_type  push_item,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output rhfe_class_type  pop_item
);

   rhfe_class_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_pop;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item = slot_ff[rd_ptr_ff];
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/rhfe_back.sv
`timescale 1ns / 1ps
// Back end: key matcher, hex decoder, brace counter and the response register.
module rhfe_back
   import rhfe_pkg::*;
#(
   parameter int DEPTH_BITS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  rhfe_class_type  item,
   output logic            pop,
   rhfe_rsp_if.source      rsp_chan
);

   localparam logic signed [DEPTH_BITS-1:0] DEPTH_TOP = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_BOTTOM = {1'b1, {(DEPTH_BITS-1){1'b0}}};

   logic [PROG_W-1:0]            progress_ff, progress_in;
   logic                         in_run_ff, in_run_in;
   logic                         odd_ff, odd_in;
   logic [3:0]                   high_ff, high_in;
   logic signed [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                         armed_ff, armed_in;
   logic                         rsp_valid_ff;
   logic                         byte_valid_ff, byte_valid_in;
   logic [7:0]                   data_ff, data_in;
   logic [PROG_W-1:0]            q_base;
   logic [PROG_W-1:0]            q_next;

   // The response register is free when empty or being drained this cycle.
   assign pop = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.byte_valid = byte_valid_ff;
   assign rsp_chan.data_byte = data_ff;
   assign rsp_chan.awaiting = armed_ff;

   always_comb begin
      q_base = (progress_ff >= PROG_W'(KEY_LEN)) ? '0 : progress_ff;
      if (item.key_hit[q_base]) begin
         q_next = q_base + PROG_W'(1);
      end else if (item.is_quote) begin
         q_next = PROG_W'(1);
      end else begin
         q_next = '0;
      end
   end

   always_comb begin
      progress_in = progress_ff;
      in_run_in = in_run_ff;
      odd_in = odd_ff;
      high_in = high_ff;
      depth_in = depth_ff;
      armed_in = armed_ff;
      byte_valid_in = 1'b0;
      data_in = 8'd0;
      if (item.arm) begin
         armed_in = 1'b1;
         depth_in = '0;
      end else begin
         if (armed_ff) begin
            if (item.is_open) begin
               if (depth_ff != DEPTH_TOP) begin
                  depth_in = depth_ff + DEPTH_BITS'(1);
               end
            end else if (item.is_close) begin
               if (depth_ff != DEPTH_BOTTOM) begin
                  depth_in = depth_ff - DEPTH_BITS'(1);
               end
               if (depth_in == '0) begin
                  armed_in = 1'b0;
               end
            end
         end
         if (!in_run_ff) begin
            if (q_next >= PROG_W'(KEY_LEN)) begin
               progress_in = '0;
               in_run_in = 1'b1;
               odd_in = 1'b0;
            end else begin
               progress_in = q_next;
            end
         end else if (item.is_quote) begin
            in_run_in = 1'b0;
            odd_in = 1'b0;
         end else if (odd_ff) begin
            byte_valid_in = 1'b1;
            data_in = {high_ff, item.nibble};
            odd_in = 1'b0;
         end else begin
            high_in = item.nibble;
            odd_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= '0;
         in_run_ff <= 1'b0;
         odd_ff <= 1'b0;
         high_ff <= 4'd0;
         depth_ff <= '0;
         armed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            progress_ff <= progress_in;
            in_run_ff <= in_run_in;
            odd_ff <= odd_in;
            high_ff <= high_in;
            depth_ff <= depth_in;
            armed_ff <= armed_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_valid_ff <= byte_valid_in;
         data_ff <= data_in;
      end
   end

endmodule

FILE: sv/relay_hex_field_extractor_top.sv
`timescale 1ns / 1ps
// Top level of the relay hex field extractor: front, queue and back joined.
// Path: a transaction accepted by the front is written into the queue and later loaded
// into the response register once that register is empty or being drained.
// Throughput: one transaction per cycle while the response side keeps ready high.
// Reset: synchronous, active high; the queue empties, the block is disarmed and searching.
module relay_hex_field_extractor_top
   import rhfe_pkg::*;
#(
   parameter int DEPTH_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   rhfe_req_if.sink    req_chan,
   rhfe_rsp_if.source  rsp_chan
);

   // The front classifies each character once: brace, quote, hex value and a
   // hit vector against every position of the key, so the back only selects.
   rhfe_class_type push_item;
   rhfe_class_type pop_item;
   logic           push;
   logic           queue_full;
   logic           queue_not_empty;
   logic           pop;

   rhfe_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // The queue lets the request side keep streaming while the response side
   // stalls, and two entries keep a full rate across the ready turnaround.
   rhfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_item  (pop_item)
   );

   // The back holds all stream state and updates it only when a transaction
   // moves into the response register, so stalls never disturb the order.
   rhfe_back #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (pop_item),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: tb/sv/relay_hex_field_extractor_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the relay hex field extractor top level.

typedef struct packed {
   logic       byte_valid;
   logic [7:0] data_byte;
   logic       awaiting;
} relay_result_type;

typedef struct packed {
   logic       mode;
   logic [7:0] ch;
} relay_req_type;

// Tracks the key search, the hex decoder and the brace counter of the block and holds the
// responses that are still to come, oldest first.
class relay_byte_scoreboard;
   int unsigned      key_pos;
   bit               in_run;
   bit               odd_digit;
   logic [3:0]       high_nib;
   int               depth;
   int               depth_top;
   int               depth_bottom;
   bit               armed;
   int unsigned      failures;
   relay_result_type pending_bytes[$];

   function new(int depth_bits);
      depth_top = (1 << (depth_bits - 1)) - 1;
      depth_bottom = -(1 << (depth_bits - 1));
      key_pos = 0;
      in_run = 1'b0;
      odd_digit = 1'b0;
      high_nib = 4'd0;
      depth = 0;
      armed = 1'b0;
      failures = 0;
   endfunction

   function logic [3:0] hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      return 4'd0;
   endfunction

   function void note_request(relay_req_type t);
      relay_result_type r;
      int unsigned      q;
      logic [3:0]       nib;
      r = '0;
      if (t.mode == rhfe_pkg::MODE_ARM) begin
         armed = 1'b1;
         depth = 0;
      end else begin
         // Braces are counted first, then the same character is searched or decoded.
         if (armed) begin
            if (t.ch == rhfe_pkg::CH_OPEN) begin
               if (depth < depth_top) depth++;
            end else if (t.ch == rhfe_pkg::CH_CLOSE) begin
               if (depth > depth_bottom) depth--;
               if (depth == 0) armed = 1'b0;
            end
         end
         if (!in_run) begin
            q = (key_pos >= rhfe_pkg::KEY_LEN) ? 0 : key_pos;
            if (t.ch == rhfe_pkg::RELAY_KEY[q]) q++;
            else if (t.ch == rhfe_pkg::CH_QUOTE) q = 1;
            else q = 0;
            if (q >= rhfe_pkg::KEY_LEN) begin
               key_pos = 0;
               in_run = 1'b1;
               odd_digit = 1'b0;
            end else begin
               key_pos = q;
            end
         end else if (t.ch == rhfe_pkg::CH_QUOTE) begin
            in_run = 1'b0;
            odd_digit = 1'b0;
         end else begin
            nib = hex_value(t.ch);
            if (odd_digit) begin
               r.byte_valid = 1'b1;
               r.data_byte = {high_nib, nib};
               odd_digit = 1'b0;
            end else begin
               high_nib = nib;
               odd_digit = 1'b1;
            end
         end
      end
      r.awaiting = armed;
      pending_bytes.push_back(r);
   endfunction

   function void check_response(relay_result_type got);
      relay_result_type want;
      if (pending_bytes.size() == 0) begin
         $error("unexpected response: byte_valid %0d, data_byte %0h, awaiting %0d",
                got.byte_valid, got.data_byte, got.awaiting);
         failures++;
         return;
      end
      want = pending_bytes.pop_front();
      if (got.byte_valid !== want.byte_valid) begin
         $error("byte_valid mismatch: expected %0d, actual %0d", want.byte_valid, got.byte_valid);
         failures++;
      end
      if (got.data_byte !== want.data_byte) begin
         $error("data_byte mismatch: expected %0h, actual %0h", want.data_byte, got.data_byte);
         failures++;
      end
      if (got.awaiting !== want.awaiting) begin
         $error("awaiting mismatch: expected %0d, actual %0d", want.awaiting, got.awaiting);
         failures++;
      end
   endfunction
endclass

module relay_hex_field_extractor_top_tb;
   import rhfe_pkg::*;

   localparam int DEPTH_BITS = 8;
   localparam int unsigned RANDOM_ITEMS = 1950;
   // The slowest correct run stays well under a third of this, even with the longest
   // stalls falling on both sides for every transaction.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   logic clock;
   logic reset;

   rhfe_req_if req_if ();
   rhfe_rsp_if rsp_if ();

   relay_hex_field_extractor_top #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   relay_byte_scoreboard sb = new(DEPTH_BITS);

   relay_req_type stim_q[$];
   int unsigned   items_sent;
   int unsigned   cycle_count;
   // While set, neither side inserts idle cycles, so back-to-back traffic is covered too.
   bit            quiet_phase;

   // Free-running clock with a 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Every input of the block is known from time zero. Reset is held from time zero
   // and released at a falling edge, so the block sees it cleanly at the next rising edge.
   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode = MODE_CHAR;
      req_if.ch = 8'h00;
      rsp_if.ready = 1'b0;
      quiet_phase = 1'b0;
      items_sent = 0;
      cycle_count = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int unsigned idle_cycles();
      int unsigned r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] rand_hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   // Any byte except the double quote, so that a hex run is not closed early.
   function automatic logic [7:0] random_plain_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == CH_QUOTE) c = "g";
      return c;
   endfunction

   task automatic push_char(logic [7:0] c);
      stim_q.push_back('{mode: MODE_CHAR, ch: c});
   endtask

   // The character byte of an arm transaction is ignored, so it is random.
   task automatic push_arm();
      stim_q.push_back('{mode: MODE_ARM, ch: 8'($urandom_range(0, 255))});
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   // Drives the queued transactions one after another. Inputs change only at falling edges;
   // a transaction is done at the first rising edge that sees ready high.
   task automatic send_all();
      relay_req_type t;
      int unsigned   gap;
      while (stim_q.size() != 0) begin
         t = stim_q.pop_front();
         gap = idle_cycles();
         @(negedge clock);
         if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_if.valid = 1'b1;
         req_if.mode = t.mode;
         req_if.ch = t.ch;
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         items_sent++;
      end
   endtask

   // The response side alternates stalls and stretches of readiness of random length.
   initial begin
      int unsigned gap;
      int unsigned run;
      @(negedge reset);
      forever begin
         gap = idle_cycles();
         run = $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            rsp_if.ready = 1'b0;
         end
         repeat (run) begin
            @(negedge clock);
            rsp_if.ready = 1'b1;
         end
      end
   end

   // Both channels are observed at the rising edge. An accepted request transaction is
   // predicted at once; an accepted response transaction is compared with the oldest
   // prediction still waiting.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_request('{mode: req_if.mode, ch: req_if.ch});
         end
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_response('{byte_valid: rsp_if.byte_valid, data_byte: rsp_if.data_byte,
                                awaiting: rsp_if.awaiting});
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int unsigned kind;
      int unsigned n;
      int unsigned iter;

      @(negedge reset);

      // Directed part. A brace before any arm transaction is not counted.
      push_char(CH_OPEN);
      push_arm();
      push_char(CH_OPEN);
      push_char(CH_OPEN);
      push_char(CH_CLOSE);
      // A doubled opening quote: the matcher restarts on the second one and still finds
      // the key.
      push_text("\"\"relay\":\"");
      // Upper and lower case digits, then a non-hex character that decodes as zero.
      push_text("Af09Fz");
      // A dangling high nibble is dropped by the closing quote.
      push_char("7");
      push_char(CH_QUOTE);
      // Closing the last brace brings the depth back to zero and disarms.
      push_char(CH_CLOSE);
      push_char(8'hFF);
      push_char(8'h00);
      stim_q.push_back('{mode: MODE_ARM, ch: 8'hFF});
      send_all();

      // Random part, built as short sequences. Half are well-formed responses with random
      // content; the rest are broken keys, noise and runs of arbitrary bytes. The first two
      // sequences drive the brace depth into both saturation limits.
      iter = 0;
      while (items_sent < RANDOM_ITEMS + 25) begin
         quiet_phase = ($urandom_range(0, 7) == 0);
         if (iter == 0) kind = 200;
         else if (iter == 1) kind = 201;
         else kind = $urandom_range(0, 99);
         iter++;

         if (kind < 50) begin
            if ($urandom_range(0, 9) != 0) push_arm();
            push_char(CH_OPEN);
            if ($urandom_range(0, 1) == 1) begin
               push_text("\"id\":");
               push_char(8'(8'h30 + $urandom_range(0, 9)));
               push_text(",");
            end
            if ($urandom_range(0, 2) == 0) push_text("\"n\":{\"x\":1},");
            // Near misses and overlapping prefixes in front of the key.
            case ($urandom_range(0, 5))
               0: push_text("\"rel");
               1: push_text("\"relay\"");
               2: push_text("\"\"");
               3: push_text("\"relay\":");
               default: ;
            endcase
            push_text("\"relay\":\"");
            n = $urandom_range(0, 6);
            repeat (n) begin
               push_char(rand_hex_char());
               if ($urandom_range(0, 9) == 0) push_char(random_plain_byte());
               else push_char(rand_hex_char());
            end
            if ($urandom_range(0, 5) == 0) push_char(rand_hex_char());
            push_char(CH_QUOTE);
            push_char(CH_CLOSE);
         end else if (kind < 65) begin
            // A key cut short, followed by an arbitrary byte.
            n = $urandom_range(1, KEY_LEN - 1);
            for (int i = 0; i < n; i++) push_char(RELAY_KEY[i]);
            push_char(8'($urandom_range(0, 255)));
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 12)) begin
               if ($urandom_range(0, 9) == 0) push_arm();
               else push_char(8'($urandom_range(0, 255)));
            end
         end else if (kind < 100) begin
            push_text("\"relay\":\"");
            repeat ($urandom_range(2, 10)) push_char(random_plain_byte());
            push_char(CH_QUOTE);
         end else if (kind == 200) begin
            // Up past the positive limit, then back down to zero or just short of it.
            push_arm();
            repeat ($urandom_range(128, 140)) push_char(CH_OPEN);
            repeat ($urandom_range(125, 129)) push_char(CH_CLOSE);
         end else begin
            // Down past the negative limit; opening back up through zero does not disarm.
            push_arm();
            repeat ($urandom_range(129, 136)) push_char(CH_CLOSE);
            repeat ($urandom_range(127, 131)) push_char(CH_OPEN);
            repeat ($urandom_range(1, 5)) push_char(CH_CLOSE);
         end
         send_all();
      end

      @(negedge clock);
      req_if.valid = 1'b0;
      quiet_phase = 1'b0;

      // Drain the outstanding responses, then keep watching the response channel so that a
      // stray extra response would still be caught.
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (sb.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
